[rtl/quadrotor_attitude_compensator_mixer_unit_assert.svh]
// assertion macros for the attitude compensator and mixer
`ifndef QUADROTOR_ATTITUDE_COMPENSATOR_MIXER_UNIT_ASSERT_SVH
`define QUADROTOR_ATTITUDE_COMPENSATOR_MIXER_UNIT_ASSERT_SVH
`define QAC_ASSERT_IMP(lbl, clk_s, rst_n, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define QAC_ASSERT_NEXT(lbl, clk_s, rst_n, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`endif

[rtl/qacm_pkg.sv]
// ----------------------------------------------------------------------------
// qacm_pkg
// shared types and constants of the attitude compensator and mixer
// ----------------------------------------------------------------------------
`default_nettype none
package qacm_pkg;
	localparam int AXES = 3;
	localparam int ANGLE_W = 16;
	localparam int ERR_W = 17;
	localparam int DRV_W = 32;
	localparam int COEF_W = 16;
	localparam int REG_IDX_W = 3;
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_ROLL_TGT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_TGT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_YAW_TGT   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LIFT      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ARM       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_THRUST    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DRAG      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED    = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LANE, ST_DIV, ST_MIX, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

	function automatic logic [16:0] coef_a(input logic is_yaw);
		return is_yaw ? 17'sd18104 : 17'sd17285;
	endfunction
	function automatic logic [16:0] coef_b(input logic is_yaw);
		return is_yaw ? 17'sd17531 : 17'sd16499;
	endfunction
	function automatic logic [16:0] coef_c(input logic is_yaw);
		return is_yaw ? 17'sd13984 : 17'sd12971;
	endfunction
	function automatic logic [15:0] nz16(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction
endpackage
`default_nettype wire

[rtl/qacm_lane.sv]
// ----------------------------------------------------------------------------
// qacm_lane
// one axis lead-lag compensator: two-stage multiply, round, saturate
// ----------------------------------------------------------------------------
`default_nettype none
module qacm_lane #(
	parameter logic IS_YAW = 1'b0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [qacm_pkg::ANGLE_W-1:0] target,
	input  wire logic signed [qacm_pkg::ANGLE_W-1:0] angle,
	output logic signed [qacm_pkg::DRV_W-1:0] drive,
	output logic sat,
	output logic done
);
	logic signed [qacm_pkg::ERR_W-1:0] err_s1, prev_err_q;
	logic signed [qacm_pkg::DRV_W-1:0] prev_drv_q;
	logic signed [49:0] pa_s1, pb_s1, pc_s1;
	logic v1_s1, v2_s2;
	logic signed [51:0] sum, rnd;
	logic signed [37:0] sh;
	logic signed [qacm_pkg::ERR_W-1:0] err_c;

	assign err_c = qacm_pkg::ERR_W'(target) - qacm_pkg::ERR_W'(angle);
	assign sum = 52'(pa_s1) - 52'(pb_s1) + 52'(pc_s1) + 52'sd8192;
	assign rnd = sum >>> 14;
	assign sh = 38'(rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			prev_err_q <= '0;
			prev_drv_q <= '0;
		end else begin
			v1_s1 <= start;
			v2_s2 <= v1_s1;
			if (v1_s1) begin
				prev_err_q <= err_s1;
				if (sh > 38'sd2147483647) begin
					prev_drv_q <= 32'sh7fffffff;
				end else if (sh < -38'sd2147483648) begin
					prev_drv_q <= 32'sh80000000;
				end else begin
					prev_drv_q <= 32'(sh);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			err_s1 <= err_c;
			pa_s1 <= 50'($signed(qacm_pkg::coef_a(IS_YAW))) * 50'(err_c);
			pb_s1 <= 50'($signed(qacm_pkg::coef_b(IS_YAW))) * 50'(prev_err_q);
			pc_s1 <= 50'($signed(qacm_pkg::coef_c(IS_YAW))) * 50'(prev_drv_q);
		end
		if (v1_s1) begin
			sat <= (sh > 38'sd2147483647) || (sh < -38'sd2147483648);
		end
	end

	assign drive = prev_drv_q;
	assign done = v2_s2;
endmodule
`default_nettype wire

[rtl/qacm_div.sv]
// ----------------------------------------------------------------------------
// qacm_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none
module qacm_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [qacm_pkg::DIV_N_W-1:0] num,
	input  wire logic [qacm_pkg::DIV_D_W-1:0] den,
	output logic signed [qacm_pkg::DIV_N_W-1:0] quo,
	output qacm_pkg::div_ctl_t ctl
);
	localparam int CW = $clog2(qacm_pkg::DIV_N_W + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q, neg_q;
	logic [qacm_pkg::DIV_N_W-1:0] q_q;
	logic [qacm_pkg::DIV_D_W:0] rem_q;
	logic [qacm_pkg::DIV_D_W-1:0] den_q;
	logic [qacm_pkg::DIV_D_W:0] trial;

	assign trial = {rem_q[qacm_pkg::DIV_D_W-1:0], q_q[qacm_pkg::DIV_N_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(qacm_pkg::DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[qacm_pkg::DIV_N_W-1];
			q_q <= num[qacm_pkg::DIV_N_W-1] ? -num : num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q <= {q_q[qacm_pkg::DIV_N_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[qacm_pkg::DIV_N_W-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
endmodule
`default_nettype wire

[rtl/quadrotor_attitude_compensator_mixer_unit.sv]
// an accepted item passes through the three parallel lanes, then four divides on one
// shared divider and the mix state, before its result is offered
// throughput: one item at a time
// reset: asynchronous, clears compensator state and loads register defaults
// ----------------------------------------------------------------------------
// quadrotor_attitude_compensator_mixer_unit
// three parallel axis compensators merged by a shared-divider motor mixer
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadrotor_attitude_compensator_mixer_unit_assert.svh"
module quadrotor_attitude_compensator_mixer_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [qacm_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [15:0] roll_angle,
	input  wire logic signed [15:0] pitch_angle,
	input  wire logic signed [15:0] yaw_angle,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [31:0] roll_drive,
	output logic signed [31:0] pitch_drive,
	output logic signed [31:0] yaw_drive,
	output logic signed [31:0] rotor1_speed_sq,
	output logic signed [31:0] rotor2_speed_sq,
	output logic signed [31:0] rotor3_speed_sq,
	output logic signed [31:0] rotor4_speed_sq,
	output logic saturated
);
	logic signed [15:0] roll_tgt_q, pitch_tgt_q, yaw_tgt_q;
	logic [15:0] lift_q, arm_q, thrust_q, drag_q;
	qacm_pkg::state_t state_q, state_d;
	logic [1:0] term_q, term_sel;
	logic [2:0] lane_done, lane_sat;
	logic signed [31:0] drv [3];
	logic lane_start, div_start;
	logic signed [47:0] div_num, div_quo;
	logic [31:0] div_den, lb_q;
	qacm_pkg::div_ctl_t div_ctl;
	logic signed [47:0] t1_q, t2_q, t3_q, t4_q;
	logic signed [50:0] r [4];
	logic [3:0] rsat;
	logic accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_tgt_q <= '0; pitch_tgt_q <= '0; yaw_tgt_q <= '0; lift_q <= '0;
			arm_q <= 16'd256; thrust_q <= 16'd256; drag_q <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qacm_pkg::REG_ROLL_TGT:  roll_tgt_q <= cfg_data;
				qacm_pkg::REG_PITCH_TGT: pitch_tgt_q <= cfg_data;
				qacm_pkg::REG_YAW_TGT:   yaw_tgt_q <= cfg_data;
				qacm_pkg::REG_LIFT:      lift_q <= cfg_data;
				qacm_pkg::REG_ARM:       arm_q <= cfg_data;
				qacm_pkg::REG_THRUST:    thrust_q <= cfg_data;
				qacm_pkg::REG_DRAG:      drag_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lane_start = accept;

	qacm_lane #(.IS_YAW(1'b0)) u_roll (.clk, .arst_n, .start(lane_start),
		.target(roll_tgt_q), .angle(roll_angle), .drive(drv[0]),
		.sat(lane_sat[0]), .done(lane_done[0]));
	qacm_lane #(.IS_YAW(1'b0)) u_pitch (.clk, .arst_n, .start(lane_start),
		.target(pitch_tgt_q), .angle(pitch_angle), .drive(drv[1]),
		.sat(lane_sat[1]), .done(lane_done[1]));
	qacm_lane #(.IS_YAW(1'b1)) u_yaw (.clk, .arst_n, .start(lane_start),
		.target(yaw_tgt_q), .angle(yaw_angle), .drive(drv[2]),
		.sat(lane_sat[2]), .done(lane_done[2]));

	// a divide started as the previous one finishes takes the next term
	assign term_sel = (state_q == qacm_pkg::ST_DIV) ? term_q + 2'd1 : term_q;

	// divide operands per mixer term
	always_comb begin
		case (term_sel)
			2'd0: begin
				div_num = 48'($signed({1'b0, lift_q, 6'd0}));
				div_den = 32'(qacm_pkg::nz16(thrust_q));
			end
			2'd1: begin
				div_num = 48'({drv[0], 15'd0});
				div_den = lb_q;
			end
			2'd2: begin
				div_num = 48'({drv[1], 15'd0});
				div_den = lb_q;
			end
			default: begin
				div_num = 48'({drv[2], 6'd0});
				div_den = 32'(qacm_pkg::nz16(drag_q));
			end
		endcase
		div_num = (term_sel == 2'd1 || term_sel == 2'd2)
			? $signed(48'($signed(div_num[46:0]))) : div_num;
		if (term_sel == 2'd3) div_num = $signed(48'($signed(div_num[37:0])));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qacm_pkg::ST_IDLE: if (accept) state_d = qacm_pkg::ST_LANE;
			qacm_pkg::ST_LANE: if (lane_done[0]) state_d = qacm_pkg::ST_DIV;
			qacm_pkg::ST_DIV: if (div_ctl.done && term_q == 2'd3) state_d = qacm_pkg::ST_MIX;
			qacm_pkg::ST_MIX: state_d = qacm_pkg::ST_OUT;
			qacm_pkg::ST_OUT: if (out_ready) state_d = qacm_pkg::ST_IDLE;
			default: state_d = qacm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == qacm_pkg::ST_IDLE);
		out_valid = (state_q == qacm_pkg::ST_OUT);
		div_start = (state_q == qacm_pkg::ST_LANE && lane_done[0]) ||
			(state_q == qacm_pkg::ST_DIV && div_ctl.done && term_q != 2'd3);
	end

	qacm_div u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.quo(div_quo), .ctl(div_ctl));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qacm_pkg::ST_IDLE;
			term_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) term_q <= '0;
			else if (div_ctl.done) term_q <= term_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) lb_q <= 32'(qacm_pkg::nz16(arm_q)) * 32'(qacm_pkg::nz16(thrust_q));
		if (div_ctl.done) begin
			case (term_q)
				2'd0: t1_q <= div_quo;
				2'd1: t2_q <= div_quo;
				2'd2: t3_q <= div_quo;
				default: t4_q <= div_quo;
			endcase
		end
	end

	assign r[0] = 51'(t1_q) - 51'(t3_q) - 51'(t4_q);
	assign r[1] = 51'(t1_q) - 51'(t2_q) + 51'(t4_q);
	assign r[2] = 51'(t1_q) + 51'(t3_q) - 51'(t4_q);
	assign r[3] = 51'(t1_q) + 51'(t2_q) + 51'(t4_q);

	logic signed [31:0] rs [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rsat[i] = (r[i] > 51'sd2147483647) || (r[i] < -51'sd2147483648);
			rs[i] = (r[i] > 51'sd2147483647) ? 32'sh7fffffff :
				(r[i] < -51'sd2147483648) ? 32'sh80000000 : 32'(r[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == qacm_pkg::ST_MIX) begin
			roll_drive <= drv[0];
			pitch_drive <= drv[1];
			yaw_drive <= drv[2];
			rotor1_speed_sq <= rs[0];
			rotor2_speed_sq <= rs[1];
			rotor3_speed_sq <= rs[2];
			rotor4_speed_sq <= rs[3];
			saturated <= (|lane_sat) || (|rsat);
		end
	end

	`QAC_ASSERT_IMP(a_lanes_sync, clk, arst_n, lane_done[0], lane_done[1] && lane_done[2])
	`QAC_ASSERT_IMP(a_div_idle, clk, arst_n, div_start, !div_ctl.busy)
	`QAC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire
